// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/bfiq_pkg.sv -----
// ----------------------------------------------------------------------------
// bfiq_pkg
// shared constants and types of the bloom filter block
// ----------------------------------------------------------------------------
package bfiq_pkg;

  localparam int MAX_BITS   = 1048576;
  localparam int MAX_PROBES = 16;

  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = MAX_BITS / WORD_BITS;
  localparam int WADDR_W    = $clog2(WORD_COUNT);
  localparam int BITSEL_W   = $clog2(WORD_BITS);
  localparam int IDX_W      = $clog2(MAX_BITS);

  localparam int HASH_W     = 32;
  localparam int NCNT_W     = 21;
  localparam int KCNT_W     = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(HASH_W);

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 8'd1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] mag;
    logic [NCNT_W-1:0] modulus;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- hw/rtl/bfiq_ram.sv -----
// ----------------------------------------------------------------------------
// bfiq_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfiq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bfiq_mod.sv -----
// ----------------------------------------------------------------------------
// bfiq_mod
// bit serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bfiq_mod (
  input  logic                clk,
  input  logic                rst_n,
  input  bfiq_pkg::div_req_t  req,
  output bfiq_pkg::div_rsp_t  rsp
);
  import bfiq_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [HASH_W-1:0]    mag_r;
  logic [NCNT_W-1:0]    mod_r;
  logic [IDX_W-1:0]     rem_r;
  logic [IDX_W-1:0]     rem_nxt;
  logic [NCNT_W-1:0]    shifted;
  logic [NCNT_W-1:0]    diff;

  assign shifted = {rem_r, mag_r[HASH_W-1]};
  assign diff    = shifted - mod_r;
  assign rem_nxt = (shifted >= mod_r) ? diff[IDX_W-1:0] : shifted[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r && cnt_r == DIV_CNT_W'(HASH_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      rem_r <= '0;
      mag_r <= req.mag;
      mod_r <= req.modulus;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      mag_r <= {mag_r[HASH_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ----- hw/rtl/bloom_filter_insert_query_top.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top
// bloom filter over a 1M bit array with add and query requests
// ----------------------------------------------------------------------------
// After reset the block clears its 16384-word filter memory, one word per
// cycle, and takes no request until that is done. Each request makes p
// probes (hash_count, capped at 16, or fewer for a query that meets a clear
// bit): the first probe index comes from a bit-serial remainder unit, each
// later index is stepped by one from the previous one, and every probe reads
// the filter memory, an add also writing the word back with the bit set. The
// default is three probes. A request with no probes skips the remainder unit
// and the memory. The result shows on the output as the block becomes ready
// for the next request, and a request is accepted while the previous result
// still waits on the output.
module bloom_filter_insert_query_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [bfiq_pkg::HASH_W-1:0]   in_key_hash,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_found,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bfiq_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [NCNT_W-1:0]   bit_count_r;
  logic [KCNT_W-1:0]   hash_count_r;
  logic [WADDR_W-1:0]  clr_cnt_r;
  logic                mode_r;
  logic                found_r, found_nxt;
  logic [HASH_W:0]     s_r, s_nxt;
  logic [NCNT_W-1:0]   n_r;
  logic [KCNT_W-1:0]   k_r;
  logic [KCNT_W-1:0]   probe_r, probe_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                out_valid_r;
  logic                out_found_r;

  logic [NCNT_W-1:0]   n_eff;
  logic [KCNT_W-1:0]   k_eff;
  logic [HASH_W-1:0]   key_mag;
  logic                in_acc;
  logic                out_free;
  logic [NCNT_W-1:0]   idx_inc;
  logic [NCNT_W-1:0]   n_last;
  logic [IDX_W-1:0]    idx_up;
  logic [IDX_W-1:0]    idx_dn;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] bit_mask;
  logic                probe_bit;
  logic                ram_we;
  logic [WADDR_W-1:0]  ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                ram_re;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= NCNT_W'(MAX_BITS);
      hash_count_r <= KCNT_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIT_COUNT:  bit_count_r  <= cfg_data[NCNT_W-1:0];
        REG_HASH_COUNT: hash_count_r <= cfg_data[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (bit_count_r == '0) ? NCNT_W'(1) :
                 (bit_count_r > NCNT_W'(MAX_BITS)) ? NCNT_W'(MAX_BITS) : bit_count_r;
  assign k_eff = (hash_count_r > KCNT_W'(MAX_PROBES)) ? KCNT_W'(MAX_PROBES)
                                                       : hash_count_r;

  assign key_mag = in_key_hash[HASH_W-1] ? (~$unsigned(in_key_hash) + 1'b1)
                                         : $unsigned(in_key_hash);

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign div_req.start   = in_acc && (k_eff != '0);
  assign div_req.mag     = key_mag;
  assign div_req.modulus = n_eff;

  bfiq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next probe index: |s| moves by one per seed
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign n_last  = n_r - 1'b1;
  assign idx_up  = (idx_inc == n_r) ? '0 : idx_inc[IDX_W-1:0];
  assign idx_dn  = (idx_r == '0) ? n_last[IDX_W-1:0] : idx_r - 1'b1;
  assign s_nxt   = s_r + 1'b1;
  assign probe_nxt = probe_r + 1'b1;

  assign bit_mask  = WORD_BITS'(1) << idx_r[BITSEL_W-1:0];
  assign probe_bit = rdata[idx_r[BITSEL_W-1:0]];

  assign ram_re    = (state_r == ST_RD);
  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_CHK && mode_r == MODE_ADD);
  assign ram_waddr = (state_r == ST_CLR) ? clr_cnt_r : idx_r[IDX_W-1:BITSEL_W];
  assign ram_wdata = (state_r == ST_CLR) ? '0 : (rdata | bit_mask);

  bfiq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[IDX_W-1:BITSEL_W]),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_cnt_r == WADDR_W'(WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          found_nxt = in_mode;
          state_nxt = (k_eff == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          idx_nxt   = div_rsp.rem;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        idx_nxt = s_r[HASH_W] ? idx_dn : idx_up;
        if (mode_r == MODE_QUERY && !probe_bit) begin
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
        end else if (probe_nxt == k_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    idx_r   <= idx_nxt;
    if (in_acc) begin
      mode_r  <= in_mode;
      s_r     <= {in_key_hash[HASH_W-1], in_key_hash};
      n_r     <= n_eff;
      k_r     <= k_eff;
      probe_r <= '0;
    end else if (state_r == ST_CHK) begin
      s_r     <= s_nxt;
      probe_r <= probe_nxt;
    end
    if (state_r == ST_FIN && out_free) begin
      out_found_r <= found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

`include "assert_macros.svh"

  `ASSERT_HOLDS(a_done_in_div, clk, rst_n, div_rsp.done |-> state_r == ST_DIV)
  `ASSERT_HOLDS(a_probe_bound, clk, rst_n, state_r == ST_CHK |-> probe_r < k_r)
  `ASSERT_HOLDS(a_idx_range, clk, rst_n, state_r == ST_RD |-> {1'b0, idx_r} < n_r)
  `ASSERT_NEVER(a_query_write, clk, rst_n, ram_we && state_r == ST_CHK && mode_r == MODE_QUERY)

endmodule

// ----- tb/sv/bloom_filter_insert_query_checker.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_checker
// tracks the filter contents and checks every found flag the block returns
// ----------------------------------------------------------------------------
// Watches the request, result and register channels. Keeps a private copy of
// the bit array and of both registers, works out the found flag of every
// accepted request and compares it, in order, with the returned results.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [bfiq_pkg::HASH_W-1:0]   in_key_hash,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_found,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatch_count,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bfiq_pkg::*;

  localparam int RESET_HASH_COUNT = 3;

  bit [WORD_BITS-1:0] filter_words [WORD_COUNT];
  logic [NCNT_W-1:0]  bit_count_reg;
  logic [KCNT_W-1:0]  hash_count_reg;
  bit                 expected_found [$];
  bit                 want_found;

  function automatic bit probe_filter(input logic mode, input logic signed [HASH_W-1:0] key);
    int unsigned span;
    int unsigned probes;
    int unsigned seed;
    int unsigned idx;
    longint      sum;
    longint      mag;
    bit          hit;
    span = (bit_count_reg == 0) ? 1 : bit_count_reg;
    if (span > MAX_BITS) span = MAX_BITS;
    probes = (hash_count_reg > MAX_PROBES) ? MAX_PROBES : hash_count_reg;
    hit = 1'b1;
    for (seed = 0; seed < probes; seed++) begin
      sum = longint'(key) + longint'(seed);
      mag = (sum < 0) ? -sum : sum;
      idx = 32'(mag % span);
      if (mode == MODE_ADD) begin
        filter_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
      end else if (!filter_words[idx / WORD_BITS][idx % WORD_BITS]) begin
        hit = 1'b0;
      end
    end
    return (mode == MODE_QUERY) && hit;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (filter_words[w]) filter_words[w] = '0;
      bit_count_reg  = NCNT_W'(MAX_BITS);
      hash_count_reg = KCNT_W'(RESET_HASH_COUNT);
      expected_found.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_found.push_back(probe_filter(in_mode, in_key_hash));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BIT_COUNT) begin
          bit_count_reg = cfg_data[NCNT_W-1:0];
        end else if (cfg_index == REG_HASH_COUNT) begin
          hash_count_reg = cfg_data[KCNT_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        if (expected_found.size() == 0) begin
          mismatch_count++;
          $error("result with no request outstanding: found %0b", out_found);
        end else begin
          want_found = expected_found.pop_front();
          if (out_found !== want_found) begin
            mismatch_count++;
            $error("found mismatch: expected %0d, actual %0b", want_found, out_found);
          end
        end
      end
    end
    outstanding <= expected_found.size();
  end

endmodule

// ----- tb/sv/bloom_filter_insert_query_top_test.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top_test
// stimulus and verdict for the bloom filter add and query block
// ----------------------------------------------------------------------------
// Sends directed add and query requests over the corner cases of the key and
// both registers, then random phases under several register settings and
// idle patterns, including one long result hold-off that backs up the input.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfiq_pkg::*;

  localparam int HALF_PERIOD      = 6;
  localparam int RESET_CYCLES     = 8;
  localparam int SETTLE_CYCLES    = 100;
  localparam int LIMIT_CYCLES     = 1000000;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int PHASE_COUNT      = 8;
  localparam int PHASE_ITEMS      = 150;
  localparam int KEY_HISTORY      = 512;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST   = 8'hFF;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic                     in_mode     = MODE_ADD;
  logic signed [HASH_W-1:0] in_key_hash = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic                     out_found;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data    = '0;

  int mismatch_count;
  int outstanding;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_token     = 1'b0;
  bit hold_seen      = 1'b0;
  int hold_left      = 0;

  logic signed [HASH_W-1:0] added_keys [$];

  bloom_filter_insert_query_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_key_hash (in_key_hash),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_found   (out_found),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  bloom_filter_insert_query_checker found_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key_hash    (in_key_hash),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic mode, input logic signed [HASH_W-1:0] key);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_key_hash <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] bits,
                           input logic [CFG_DATA_W-1:0] probes);
    drain();
    write_reg(REG_BIT_COUNT, bits);
    write_reg(REG_HASH_COUNT, probes);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [HASH_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'sh80000000 + $urandom_range(15);
      1:       return 32'sh7fffffff - $urandom_range(15);
      2:       return $urandom_range(40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_key(input logic signed [HASH_W-1:0] key);
    added_keys.push_back(key);
    if (added_keys.size() > KEY_HISTORY) void'(added_keys.pop_front());
    send_request(MODE_ADD, key);
  endtask

  task automatic random_request();
    int                       roll;
    logic signed [HASH_W-1:0] known;
    roll = $urandom_range(99);
    if (roll < 40 || added_keys.size() == 0) begin
      add_key(pick_key());
    end else begin
      known = added_keys[$urandom_range(added_keys.size() - 1)];
      if (roll < 75) begin
        send_request(MODE_QUERY, known);
      end else if (roll < 85) begin
        send_request(MODE_QUERY, known + $urandom_range(1, 3));
      end else begin
        send_request(MODE_QUERY, pick_key());
      end
    end
  endtask

  task automatic run_directed();
    send_request(MODE_QUERY, 32'sh00000000);
    add_key(32'sh00000000);
    send_request(MODE_QUERY, 32'sh00000000);
    add_key(32'sh7fffffff);
    send_request(MODE_QUERY, 32'sh7fffffff);
    send_request(MODE_QUERY, 32'sh80000000);
    add_key(32'sh80000000);
    send_request(MODE_QUERY, 32'sh80000000);
    add_key(32'shffffffff);
    send_request(MODE_QUERY, 32'shfffffffe);
    send_request(MODE_QUERY, 32'sh12345678);
    // zero bit count acts as one bit
    configure(32'd0, 32'd2);
    send_request(MODE_QUERY, 32'sh5a5a5a5a);
    // upper data bits above the register width are dropped
    configure(32'hFFE00040, 32'hFFFFFFE4);
    add_key(32'sh7fffffff);
    send_request(MODE_QUERY, 32'sh80000000);
    // no probes at all
    configure(MAX_BITS, 32'd0);
    add_key(32'sh13579bdf);
    send_request(MODE_QUERY, 32'sh2468ace0);
    // both registers above their limits
    configure(32'h001FFFFF, 32'd31);
    add_key(32'sh40000000);
    send_request(MODE_QUERY, 32'sh40000000);
    send_request(MODE_QUERY, 32'sh40000001);
    // writes to unused indexes change nothing
    drain();
    write_reg(REG_UNUSED, 32'd5);
    write_reg(REG_LAST, 32'd1);
    cfg_valid <= 1'b0;
    send_request(MODE_QUERY, 32'sh40000000);
    configure(32'd1, 32'd1);
    add_key(32'sh80000000);
    send_request(MODE_QUERY, 32'sh00000007);
    // bits set under a wider count are still there
    configure(MAX_BITS, 32'd3);
    send_request(MODE_QUERY, 32'sh7fffffff);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       configure(MAX_BITS, 32'd3);
        1:       configure(32'd64, 32'd1);
        2:       configure(32'd1, 32'd16);
        3:       configure(32'd1000, 32'd16);
        4:       configure(MAX_BITS, 32'd16);
        5:       configure(32'd300, 32'd4);
        default: configure($urandom_range(2, 5000), $urandom_range(1, 16));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      // long result hold-off while requests keep coming
      if (phase == 4) hold_token <= ~hold_token;
      repeat (PHASE_ITEMS) random_request();
    end
    drain();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bfiq_pkg.sv
hw/rtl/bfiq_ram.sv
hw/rtl/bfiq_mod.sv
hw/rtl/bloom_filter_insert_query_top.sv
tb/sv/bloom_filter_insert_query_checker.sv
tb/sv/bloom_filter_insert_query_top_test.sv
